[src/hsv_to_rgb_converter_unit_macros.svh]
// Assertion macros shared by the HSV to RGB converter modules.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is low.
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define HSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/hsvrgb_pkg.sv]
// Shared constants, types and the divide-by-255 helper for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int unsigned HUE_FULL   = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned FULL_SCALE = 255;

    // floor(h / 360) == (h * HUE_RECIP) >> HUE_SHIFT for every 16-bit h
    localparam int unsigned HUE_RECIP  = 93207;
    localparam int unsigned HUE_SHIFT  = 25;

    localparam int unsigned N_STAGES   = 7;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    typedef struct packed {
        logic [N_STAGES-1:0] en;
        logic [N_STAGES-1:0] vld;
    } t_pipe_ctl;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

[src/hsvrgb_hue.sv]
// Hue path: reduce hue modulo 360, split into sector and scaled in-sector position.
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_hue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvrgb_pkg::t_pipe_ctl i_ctl,
    input  logic [15:0]           i_hue,
    output hsvrgb_pkg::t_sector   o_sector,
    output logic [7:0]            o_frac
);

    logic [32:0] w_prod;
    logic [15:0] w_q360;
    logic [15:0] w_hm;
    logic [2:0]  w_sec;
    logic [8:0]  w_rem9;
    logic [9:0]  w_x17;

    logic [15:0] r_h0;
    logic [7:0]  r_q0;
    logic [8:0]  r_hm1;
    hsvrgb_pkg::t_sector r_sec2;
    logic [7:0]  r_frac2;

    assign w_prod = 33'(i_hue) * 33'(hsvrgb_pkg::HUE_RECIP);

    // stage 0: quotient by 360 via reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_h0 <= i_hue;
            r_q0 <= w_prod[hsvrgb_pkg::HUE_SHIFT +: 8];
        end
    end

    assign w_q360 = 16'({8'd0, r_q0} * 16'(hsvrgb_pkg::HUE_FULL));
    assign w_hm   = r_h0 - w_q360;

    // stage 1: hue modulo 360
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_hm1 <= w_hm[8:0];
        end
    end

    always_comb begin
        w_sec = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (r_hm1 >= 9'(k * hsvrgb_pkg::SECTOR_DEG)) begin
                w_sec = 3'(k);
            end
        end
    end

    assign w_rem9 = r_hm1 - 9'({6'd0, w_sec} * 9'(hsvrgb_pkg::SECTOR_DEG));
    // position * 255 / 60 is position * 17 / 4; the position stays below 60
    assign w_x17  = {w_rem9[5:0], 4'd0} + {4'd0, w_rem9[5:0]};

    // stage 2: sector and scaled position
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_sec2  <= hsvrgb_pkg::t_sector'(w_sec);
            r_frac2 <= w_x17[9:2];
        end
    end

    assign o_sector = r_sec2;
    assign o_frac   = r_frac2;

    `HSV_ASSERT(a_hm_range, i_clk, i_rst_n, i_ctl.vld[1] |-> r_hm1 < 9'd360, "hue residue out of range")
    `HSV_ASSERT(a_frac_range, i_clk, i_rst_n, i_ctl.vld[2] |-> r_frac2 <= 8'd250, "fraction above 250")

endmodule

[src/hsvrgb_shade.sv]
// Shade path: p, q and t terms and the sector-ordered output registers.
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_shade (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsvrgb_pkg::t_pipe_ctl i_ctl,
    input  logic [7:0]            i_saturation,
    input  logic [7:0]            i_brightness_value,
    input  hsvrgb_pkg::t_sector   i_sector,
    input  logic [7:0]            i_frac,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue
);

    localparam logic [7:0] FS8 = 8'(hsvrgb_pkg::FULL_SCALE);

    logic [7:0]  r_s0, r_v0;
    logic [15:0] r_ps1;
    logic [7:0]  r_s1, r_v1;
    logic [7:0]  r_p2, r_s2, r_v2;
    logic [15:0] r_sf3, r_sr3;
    logic [7:0]  r_p3, r_v3;
    hsvrgb_pkg::t_sector r_sec3;
    logic [7:0]  r_a4, r_b4, r_p4, r_v4;
    hsvrgb_pkg::t_sector r_sec4;
    logic [15:0] r_vq5, r_vt5;
    logic [7:0]  r_p5, r_v5;
    hsvrgb_pkg::t_sector r_sec5;
    logic [7:0]  r_red6, r_green6, r_blue6;

    logic [7:0]  w_q, w_t;
    logic [7:0]  n_red, n_green, n_blue;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s0 <= i_saturation;
            r_v0 <= i_brightness_value;
        end
        if (i_ctl.en[1]) begin
            r_ps1 <= {8'd0, r_v0} * {8'd0, FS8 - r_s0};
            r_s1  <= r_s0;
            r_v1  <= r_v0;
        end
        if (i_ctl.en[2]) begin
            r_p2 <= hsvrgb_pkg::div255(r_ps1);
            r_s2 <= r_s1;
            r_v2 <= r_v1;
        end
        if (i_ctl.en[3]) begin
            r_sf3  <= {8'd0, r_s2} * {8'd0, i_frac};
            r_sr3  <= {8'd0, r_s2} * {8'd0, FS8 - i_frac};
            r_p3   <= r_p2;
            r_v3   <= r_v2;
            r_sec3 <= i_sector;
        end
        if (i_ctl.en[4]) begin
            r_a4   <= FS8 - hsvrgb_pkg::div255(r_sf3);
            r_b4   <= FS8 - hsvrgb_pkg::div255(r_sr3);
            r_p4   <= r_p3;
            r_v4   <= r_v3;
            r_sec4 <= r_sec3;
        end
        if (i_ctl.en[5]) begin
            r_vq5  <= {8'd0, r_v4} * {8'd0, r_a4};
            r_vt5  <= {8'd0, r_v4} * {8'd0, r_b4};
            r_p5   <= r_p4;
            r_v5   <= r_v4;
            r_sec5 <= r_sec4;
        end
        if (i_ctl.en[6]) begin
            r_red6   <= n_red;
            r_green6 <= n_green;
            r_blue6  <= n_blue;
        end
    end

    assign w_q = hsvrgb_pkg::div255(r_vq5);
    assign w_t = hsvrgb_pkg::div255(r_vt5);

    always_comb begin
        unique case (r_sec5)
            hsvrgb_pkg::SEC_RED:    begin n_red = r_v5; n_green = w_t;  n_blue = r_p5; end
            hsvrgb_pkg::SEC_YELLOW: begin n_red = w_q;  n_green = r_v5; n_blue = r_p5; end
            hsvrgb_pkg::SEC_GREEN:  begin n_red = r_p5; n_green = r_v5; n_blue = w_t;  end
            hsvrgb_pkg::SEC_CYAN:   begin n_red = r_p5; n_green = w_q;  n_blue = r_v5; end
            hsvrgb_pkg::SEC_BLUE:   begin n_red = w_t;  n_green = r_p5; n_blue = r_v5; end
            default:                begin n_red = r_v5; n_green = r_p5; n_blue = w_q;  end
        endcase
    end

    assign o_red   = r_red6;
    assign o_green = r_green6;
    assign o_blue  = r_blue6;

    `HSV_ASSERT(a_p_le_v, i_clk, i_rst_n, i_ctl.vld[2] |-> r_p2 <= r_v2, "p term above value")
    `HSV_ASSERT(a_q_factor, i_clk, i_rst_n, i_ctl.vld[4] |-> r_a4 >= 8'd5, "q factor below 5")

endmodule

[src/hsv_to_rgb_converter_unit.sv]
// Top level of the HSV to RGB converter: stage control and the two datapath halves.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | sink      | i_valid / o_ready  | i_hue[15:0] i_saturation[7:0]
//          |           |                    | i_brightness_value[7:0]
//  out     | source    | o_valid / i_ready  | o_red[7:0] o_green[7:0] o_blue[7:0]
//
// Seven register stages; one item is accepted per cycle while o_ready is high.
// Stages: hue reciprocal multiply, modulo 360 with v*(255-s), sector split with p,
// s*f and s*(255-f), their divide by 255, v times the q and t factors, then the
// last divide by 255 and the sector mux into the output registers.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stall at the output holds only the full stages.
// Reset (synchronous, active low) clears the valid bits; data registers keep junk.
`include "hsv_to_rgb_converter_unit_macros.svh"

module hsv_to_rgb_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam int unsigned LAST = hsvrgb_pkg::N_STAGES - 1;

    logic [hsvrgb_pkg::N_STAGES-1:0] r_vld;
    logic [hsvrgb_pkg::N_STAGES-1:0] n_vld;
    logic [hsvrgb_pkg::N_STAGES-1:0] w_en;
    hsvrgb_pkg::t_pipe_ctl           w_ctl;

    hsvrgb_pkg::t_sector w_sector;
    logic [7:0]          w_frac;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        w_en[LAST] = !r_vld[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Advance valid bits with the data; hold them where the stage stalls.
    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_ctl.en  = w_en;
    assign w_ctl.vld = r_vld;

    assign o_ready = w_en[0];
    assign o_valid = r_vld[LAST];

    hsvrgb_hue u_hue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_hue    (i_hue),
        .o_sector (w_sector),
        .o_frac   (w_frac)
    );

    hsvrgb_shade u_shade (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_saturation       (i_saturation),
        .i_brightness_value (i_brightness_value),
        .i_sector           (w_sector),
        .i_frac             (w_frac),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue)
    );

    // Input back-pressure only when every stage holds an item.
    `HSV_ASSERT(a_stall_full, i_clk, i_rst_n, !o_ready |-> (&r_vld), "input stalled with a free stage")
    // An accepted item lands in the first stage.
    `HSV_ASSERT(a_accept_lands, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0], "accepted item dropped")

endmodule
